// ----- hw/rtl/mhbi_pkg.sv -----
// ----------------------------------------------------------------------------
// mhbi_pkg: shared types and constants for the max-heap block
// Command codes, status codes, default store depth and the signed compare
// used by the heap sequencer.
// ----------------------------------------------------------------------------
package mhbi_pkg;

	// Default number of heap entries
	localparam int unsigned MHBI_DEPTH = 64;

	// Fixed field widths
	localparam int unsigned VALUE_W  = 32;
	localparam int unsigned INDEX_W  = 6;
	localparam int unsigned COUNT_W  = 7;
	localparam int unsigned STATUS_W = 2;

	typedef enum logic [1:0] {
		CMD_LOAD  = 2'd0,
		CMD_BUILD = 2'd1,
		CMD_PUSH  = 2'd2,
		CMD_READ  = 2'd3
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK       = 2'd0,
		ST_FULL     = 2'd1,
		ST_BAD_READ = 2'd2
	} status_t;

	// Strict signed less-than; equal values never count as smaller
	function automatic logic s_less(input logic signed [VALUE_W-1:0] a,
	                                input logic signed [VALUE_W-1:0] b);
		return a < b;
	endfunction

endpackage

// ----- hw/rtl/mhbi_ram.sv -----
// ----------------------------------------------------------------------------
// mhbi_ram: generic simple dual-port RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module mhbi_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port, old data on a same-address collision
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

// ----- hw/rtl/max_heap_build_and_insert.sv -----
// ----------------------------------------------------------------------------
// max_heap_build_and_insert: binary max-heap with load, build, push and read
// Keeps signed 32-bit entries in a RAM and orders them with one shared
// compare unit stepped by a small sequencer (sift-up and bottom-up sift-down).
// ----------------------------------------------------------------------------
//
// Channel  Dir  Bits  Contents (low bit up)
// s_*      in   40    command[1:0], value[33:2], read_index[39:34]
// m_*      out  80    top_value[31:0], entry_count[38:32], read_value[70:39],
//                     status[72:71], zero fill
//
// Steps: load and rejected commands go straight to the result; read issues
// the RAM read, then captures the data. Push examines each level with a parent
// read, then a compare and write, and writes the root on reaching it. Build
// fetches, loads and advances per node and, per level examined, checks, reads
// left, reads right if present and decides, with a final leaf check; the single
// RAM read port sets these. Reset clears the count; no clearing pass.
// s_tready is high only while idle; a result held by m_tready stalls the block.
module max_heap_build_and_insert
	import mhbi_pkg::*;
#(
	parameter int unsigned HEAP_DEPTH = MHBI_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,  // command[1:0], value[33:2], read_index[39:34]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [79:0] m_tdata   // top_value, entry_count, read_value, status
);

	localparam int unsigned AW = $clog2(HEAP_DEPTH);
	localparam int unsigned CW = $clog2(HEAP_DEPTH + 1);
	localparam int unsigned PW = AW + 2;
	localparam int unsigned EW = CW + INDEX_W + 1;

	typedef enum logic [3:0] {
		S_IDLE,
		S_UP_CHK,
		S_UP_CMP,
		S_BLD_NODE,
		S_DN_CUR,
		S_DN_CHK,
		S_DN_LEFT,
		S_DN_RIGHT,
		S_DN_DEC,
		S_BLD_NEXT,
		S_RD_WAIT,
		S_OUT
	} state_t;

	state_t state_q;

	logic [CW-1:0]      count_q;
	logic [AW-1:0]      pos_q;
	logic [AW-1:0]      node_q;
	logic [AW-1:0]      best_q;
	logic [VALUE_W-1:0] cur_q;
	logic [VALUE_W-1:0] bv_q;
	logic [VALUE_W-1:0] top_q;
	logic [VALUE_W-1:0] rd_q;
	status_t            status_q;

	// Input fields
	cmd_t               in_cmd;
	logic [VALUE_W-1:0] in_value;
	logic [INDEX_W-1:0] in_index;
	assign in_cmd   = cmd_t'(s_tdata[1:0]);
	assign in_value = s_tdata[33:2];
	assign in_index = s_tdata[39:34];

	logic in_acc;
	assign s_tready = (state_q == S_IDLE);
	assign in_acc   = s_tvalid && s_tready;

	// Derived indexes
	logic          full;
	logic [PW-1:0] cnt_p;
	logic [PW-1:0] left_p;
	logic [PW-1:0] right_p;
	logic [AW-1:0] pos_m1;
	logic [AW-1:0] par;
	logic [EW-1:0] idx_e;
	logic          idx_ok;
	assign full    = (count_q == CW'(HEAP_DEPTH));
	assign cnt_p   = PW'(count_q);
	assign left_p  = PW'({pos_q, 1'b1});
	assign right_p = left_p + PW'(1);
	assign pos_m1  = pos_q - AW'(1);
	assign par     = pos_m1 >> 1;
	assign idx_e   = EW'(in_index);
	assign idx_ok  = (idx_e < EW'(count_q));

	// RAM ports
	logic               ram_we;
	logic [AW-1:0]      ram_waddr;
	logic [VALUE_W-1:0] ram_wdata;
	logic [AW-1:0]      ram_raddr;
	logic [VALUE_W-1:0] ram_rdata;

	mhbi_ram #(
		.WIDTH (VALUE_W),
		.DEPTH (HEAP_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Shared compare unit: operands picked by the current step
	logic [VALUE_W-1:0] cmp_a;
	logic [VALUE_W-1:0] cmp_b;
	logic               cmp_lt;
	always_comb begin
		case (state_q)
			S_UP_CMP: begin
				cmp_a = ram_rdata;
				cmp_b = cur_q;
			end
			S_DN_LEFT: begin
				cmp_a = cur_q;
				cmp_b = ram_rdata;
			end
			default: begin
				cmp_a = bv_q;
				cmp_b = ram_rdata;
			end
		endcase
		cmp_lt = s_less(cmp_a, cmp_b);
	end

	// Drive RAM read and write ports from the sequencer step
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = pos_q;
		ram_wdata = cur_q;
		ram_raddr = pos_q;
		case (state_q)
			S_IDLE: begin
				ram_raddr = idx_e[AW-1:0];
				if (in_acc && in_cmd == CMD_LOAD && !full) begin
					ram_we    = 1'b1;
					ram_waddr = count_q[AW-1:0];
					ram_wdata = in_value;
				end
			end
			S_UP_CHK: begin
				ram_raddr = par;
				ram_we    = (pos_q == '0);
			end
			S_UP_CMP: begin
				ram_we = 1'b1;
				if (cmp_lt) begin
					ram_wdata = ram_rdata;
				end
			end
			S_BLD_NODE: begin
				ram_raddr = node_q;
			end
			S_DN_CHK: begin
				ram_raddr = left_p[AW-1:0];
				ram_we    = (left_p >= cnt_p);
			end
			S_DN_LEFT: begin
				ram_raddr = right_p[AW-1:0];
			end
			S_DN_DEC: begin
				ram_we = 1'b1;
				if (best_q != pos_q) begin
					ram_wdata = bv_q;
				end
			end
			default: begin
			end
		endcase
	end

	// Sequencer, heap registers and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			status_q <= ST_OK;
		end else begin
			// Track the root so the result never needs a RAM read
			if (ram_we && ram_waddr == '0) begin
				top_q <= ram_wdata;
			end
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						rd_q <= '0;
						case (in_cmd)
							CMD_LOAD: begin
								if (full) begin
									status_q <= ST_FULL;
								end else begin
									status_q <= ST_OK;
									count_q  <= count_q + CW'(1);
								end
								state_q <= S_OUT;
							end
							CMD_PUSH: begin
								if (full) begin
									status_q <= ST_FULL;
									state_q  <= S_OUT;
								end else begin
									status_q <= ST_OK;
									count_q  <= count_q + CW'(1);
									pos_q    <= count_q[AW-1:0];
									cur_q    <= in_value;
									state_q  <= S_UP_CHK;
								end
							end
							CMD_BUILD: begin
								status_q <= ST_OK;
								node_q   <= AW'(count_q >> 1);
								state_q  <= S_BLD_NODE;
							end
							default: begin
								if (idx_ok) begin
									status_q <= ST_OK;
									state_q  <= S_RD_WAIT;
								end else begin
									status_q <= ST_BAD_READ;
									state_q  <= S_OUT;
								end
							end
						endcase
					end
				end
				// Sift up: parent read issued here, compared next cycle
				S_UP_CHK: begin
					state_q <= (pos_q == '0) ? S_OUT : S_UP_CMP;
				end
				S_UP_CMP: begin
					if (cmp_lt) begin
						pos_q   <= par;
						state_q <= S_UP_CHK;
					end else begin
						state_q <= S_OUT;
					end
				end
				// Build: visit nodes from count/2 down to the root
				S_BLD_NODE: begin
					pos_q <= node_q;
					if (PW'(node_q) >= cnt_p) begin
						state_q <= S_BLD_NEXT;
					end else begin
						state_q <= S_DN_CUR;
					end
				end
				S_DN_CUR: begin
					cur_q   <= ram_rdata;
					state_q <= S_DN_CHK;
				end
				S_DN_CHK: begin
					state_q <= (left_p >= cnt_p) ? S_BLD_NEXT : S_DN_LEFT;
				end
				S_DN_LEFT: begin
					if (cmp_lt) begin
						best_q <= left_p[AW-1:0];
						bv_q   <= ram_rdata;
					end else begin
						best_q <= pos_q;
						bv_q   <= cur_q;
					end
					state_q <= (right_p < cnt_p) ? S_DN_RIGHT : S_DN_DEC;
				end
				S_DN_RIGHT: begin
					if (cmp_lt) begin
						best_q <= right_p[AW-1:0];
						bv_q   <= ram_rdata;
					end
					state_q <= S_DN_DEC;
				end
				S_DN_DEC: begin
					if (best_q == pos_q) begin
						state_q <= S_BLD_NEXT;
					end else begin
						pos_q   <= best_q;
						state_q <= S_DN_CHK;
					end
				end
				S_BLD_NEXT: begin
					if (node_q == '0) begin
						state_q <= S_OUT;
					end else begin
						node_q  <= node_q - AW'(1);
						state_q <= S_BLD_NODE;
					end
				end
				S_RD_WAIT: begin
					rd_q    <= ram_rdata;
					state_q <= S_OUT;
				end
				// Hold the result until it is taken
				S_OUT: begin
					if (m_tready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Result item
	logic [CW+COUNT_W-1:0] cnt_ext;
	logic [VALUE_W-1:0]    top_out;
	assign cnt_ext  = (CW + COUNT_W)'(count_q);
	assign top_out  = (count_q != '0) ? top_q : '0;
	assign m_tvalid = (state_q == S_OUT);
	assign m_tdata  = {7'd0, status_q, rd_q, cnt_ext[COUNT_W-1:0], top_out};

endmodule
